### hdl/decimal_text_to_integer_top_defines.svh
// assertion macros for the decimal text to integer block
// expects clk and rst_n in the scope of each use
`ifndef DECIMAL_TEXT_TO_INTEGER_TOP_DEFINES_SVH
`define DECIMAL_TEXT_TO_INTEGER_TOP_DEFINES_SVH

// antecedent and consequent in the same cycle
`define DTOI_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent in the cycle after antecedent
`define DTOI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/dtoi_pkg.sv
// shared types and codes for the decimal text to integer block
// no dependencies
`default_nettype none
package dtoi_pkg;

  localparam int unsigned CH_W    = 8;
  localparam int unsigned VAL_W   = 64;
  localparam int unsigned ST_W    = 2;
  localparam int unsigned PH_W    = 2;
  localparam int unsigned WSEL_W  = 2;
  localparam int unsigned CIDX_W  = 1;
  localparam int unsigned CDATA_W = 2;
  localparam int unsigned PROD_W  = VAL_W + 4;

  localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_BAD_FIRST = 2'd1;
  localparam logic [ST_W-1:0] ST_OVERFLOW  = 2'd2;
  localparam logic [ST_W-1:0] ST_TRAILING  = 2'd3;

  localparam logic [PH_W-1:0] PH_FIRST  = 2'd0;
  localparam logic [PH_W-1:0] PH_DIGITS = 2'd1;
  localparam logic [PH_W-1:0] PH_SKIP   = 2'd2;

  localparam logic [WSEL_W-1:0] WSEL_16 = 2'd0;
  localparam logic [WSEL_W-1:0] WSEL_32 = 2'd1;

  localparam logic [CIDX_W-1:0] REG_SIGNED_MODE = 1'd0;
  localparam logic [CIDX_W-1:0] REG_WIDTH_SEL   = 1'd1;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [ST_W-1:0]  status;
  } result_t;

endpackage
`default_nettype wire

### hdl/dtoi_in_stage.sv
// input register for one character word
// uses dtoi_pkg
`default_nettype none
module dtoi_in_stage
  import dtoi_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CH_W-1:0] in_ch,
  input  wire logic            advance,
  output logic                 held_valid,
  output logic [CH_W-1:0]      held_ch
);

  logic            v_r;
  logic [CH_W-1:0] ch_r;

  assign in_ready   = !v_r || advance;
  assign held_valid = v_r;
  assign held_ch    = ch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (in_ready) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      ch_r <= in_ch;
    end
  end

endmodule
`default_nettype wire

### hdl/dtoi_parse.sv
// parse state and per-character step: sign, accumulate, range check
// uses dtoi_pkg and the assertion macro header
`default_nettype none
`include "decimal_text_to_integer_top_defines.svh"
module dtoi_parse
  import dtoi_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              signed_mode,
  input  wire logic [WSEL_W-1:0] width_sel,
  input  wire logic              step_en,
  input  wire logic [CH_W-1:0]   ch,
  output logic                   res_valid,
  output result_t                res
);

  logic [VAL_W-1:0] mag_r, mag_nxt;
  logic             neg_r, neg_nxt;
  logic [PH_W-1:0]  phase_r, phase_nxt;
  logic [ST_W-1:0]  err_r, err_nxt;

  logic             is_digit;
  logic [3:0]       dgt;
  logic [VAL_W-1:0] mask;
  logic [VAL_W-1:0] half;
  logic [VAL_W-1:0] lim;
  logic [PROD_W-1:0] prod;
  logic             fits;
  logic [VAL_W-1:0] signed_val;

  assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
  assign dgt      = ch[3:0];

  // width decode: top bit of the selected width and its mask
  always_comb begin
    unique case (width_sel)
      WSEL_16: begin
        mask = {{(VAL_W-16){1'b0}}, {16{1'b1}}};
        half = VAL_W'(1) << 15;
      end
      WSEL_32: begin
        mask = {{(VAL_W-32){1'b0}}, {32{1'b1}}};
        half = VAL_W'(1) << 31;
      end
      default: begin
        mask = {VAL_W{1'b1}};
        half = VAL_W'(1) << (VAL_W-1);
      end
    endcase
  end

  always_comb begin
    if (!signed_mode) begin
      lim = mask;
    end else if (neg_r) begin
      lim = half;
    end else begin
      lim = half - VAL_W'(1);
    end
  end

  // mag*10 + d against the limit, carried wide so nothing wraps
  assign prod = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 1) + PROD_W'(dgt);
  assign fits = (prod <= {4'b0, lim});

  assign signed_val = (neg_r ? (VAL_W'(0) - mag_r) : mag_r) & mask;

  always_comb begin
    mag_nxt    = mag_r;
    neg_nxt    = neg_r;
    phase_nxt  = phase_r;
    err_nxt    = err_r;
    res_valid  = 1'b0;
    res.value  = '0;
    res.status = ST_OK;
    if (step_en) begin
      if (ch == CH_NUL) begin
        res_valid = 1'b1;
        if (phase_r == PH_FIRST) begin
          res.status = ST_BAD_FIRST;
        end else if (err_r != ST_OK) begin
          res.status = err_r;
        end else begin
          res.value = signed_val;
        end
        mag_nxt   = '0;
        neg_nxt   = 1'b0;
        phase_nxt = PH_FIRST;
        err_nxt   = ST_OK;
      end else begin
        unique case (phase_r)
          PH_FIRST: begin
            if (is_digit) begin
              mag_nxt   = VAL_W'(dgt);
              phase_nxt = PH_DIGITS;
            end else if (ch == CH_MINUS && signed_mode) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_DIGITS;
            end else begin
              err_nxt   = ST_BAD_FIRST;
              phase_nxt = PH_SKIP;
            end
          end
          PH_DIGITS: begin
            if (!is_digit) begin
              err_nxt   = ST_TRAILING;
              phase_nxt = PH_SKIP;
            end else if (!fits) begin
              err_nxt   = ST_OVERFLOW;
              phase_nxt = PH_SKIP;
            end else begin
              mag_nxt = prod[VAL_W-1:0];
            end
          end
          default: begin
            // skipping to the terminator
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mag_r   <= '0;
      neg_r   <= 1'b0;
      phase_r <= PH_FIRST;
      err_r   <= ST_OK;
    end else begin
      mag_r   <= mag_nxt;
      neg_r   <= neg_nxt;
      phase_r <= phase_nxt;
      err_r   <= err_nxt;
    end
  end

  `DTOI_ASSERT_NEXT(a_clear_after_nul, res_valid, (phase_r == PH_FIRST) && (err_r == ST_OK) && (mag_r == '0) && !neg_r, "state not cleared after terminator")
  `DTOI_ASSERT_SAME(a_err_value_zero, res_valid && (res.status != ST_OK), res.value == '0, "nonzero value with error status")
  `DTOI_ASSERT_SAME(a_skip_has_err, phase_r == PH_SKIP, err_r != ST_OK, "skipping with no recorded error")

endmodule
`default_nettype wire

### hdl/dtoi_out_stage.sv
// output register for one result word
// uses dtoi_pkg
`default_nettype none
module dtoi_out_stage
  import dtoi_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire result_t          res,
  output logic                  free,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [VAL_W-1:0]      out_value,
  output logic [ST_W-1:0]       out_status
);

  logic    v_r;
  result_t res_r;

  assign free       = !v_r || out_ready;
  assign out_valid  = v_r;
  assign out_value  = res_r.value;
  assign out_status = res_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (free) begin
      v_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (free && load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

### hdl/decimal_text_to_integer_top.sv
// Decimal text to integer converter. Characters arrive one word per cycle on the in_
// channel while in_ready is high; a NUL ends the string and produces exactly one result
// word (value, status) on the out_ channel, other characters produce none. Sustained rate
// is one character per clock unless a NUL waits on a full output register. A result word
// reaches out_ registered: the NUL sits in the input register and the parse step loads
// the output register from it once that register is free.
// A NUL waits in the input register while an untaken result holds the output register;
// digits and other characters never wait on the output side. The clock period is set
// by the multiply-by-ten range check: a 68-bit three-operand add and compare against
// the selected limit. signed_mode and width_sel are written through the cfg_ port and
// must only change while the block is idle.
// depends on dtoi_pkg, dtoi_in_stage, dtoi_parse, dtoi_out_stage
`default_nettype none
module decimal_text_to_integer_top
  import dtoi_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  // character input
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [CH_W-1:0]    in_ch,
  // result output
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [VAL_W-1:0]        out_value,
  output logic [ST_W-1:0]         out_status,
  // register writes
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CIDX_W-1:0]  cfg_index,
  input  wire logic [CDATA_W-1:0] cfg_data
);

  logic              signed_mode_r;
  logic [WSEL_W-1:0] width_sel_r;

  logic              held_valid;
  logic [CH_W-1:0]   held_ch;
  logic              out_free;
  logic              advance;
  logic              res_valid;
  result_t           res;

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_mode_r <= 1'b1;
      width_sel_r   <= WSEL_32;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SIGNED_MODE: signed_mode_r <= cfg_data[0];
        REG_WIDTH_SEL:   width_sel_r   <= cfg_data[WSEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // a held character moves on unless it is a terminator facing a full output register
  assign advance = held_valid && ((held_ch != CH_NUL) || out_free);

  dtoi_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_ch      (in_ch),
    .advance    (advance),
    .held_valid (held_valid),
    .held_ch    (held_ch)
  );

  dtoi_parse u_parse (
    .clk         (clk),
    .rst_n       (rst_n),
    .signed_mode (signed_mode_r),
    .width_sel   (width_sel_r),
    .step_en     (advance),
    .ch          (held_ch),
    .res_valid   (res_valid),
    .res         (res)
  );

  dtoi_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid),
    .res        (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_value  (out_value),
    .out_status (out_status)
  );

endmodule
`default_nettype wire
